>>> hw/rtl/binary_morphology_3x3_defines.svh
// assertion helpers shared by the rtl
`ifndef BINARY_MORPHOLOGY_3X3_DEFINES_SVH
`define BINARY_MORPHOLOGY_3X3_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BMORPH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmorph check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BMORPH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmorph check failed");

`endif

>>> hw/rtl/bmorph_pkg.sv
package bmorph_pkg;

  // register map
  typedef enum logic [1:0] {
    REG_OP_MODE      = 2'd0,
    REG_ELEMENT_MASK = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } reg_idx_t;

  // operating modes, the unused code behaves as dilation
  typedef enum logic [1:0] {
    MODE_DILATE   = 2'd0,
    MODE_ERODE    = 2'd1,
    MODE_BOUNDARY = 2'd2
  } mode_t;

  localparam int DIM_W     = 12;   // width of the size registers
  localparam int ROW_W     = 13;   // row counter runs up to height plus one
  localparam int WIN_ROWS  = 3;
  localparam int WIN_BITS  = 9;
  localparam int DIM_MAX   = 4095;

  localparam logic [7:0] PIX_OBJECT = 8'd0;
  localparam logic [7:0] PIX_BACKGR = 8'd255;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [WIN_BITS-1:0] MASK_RST = 9'h1ff;

  // shift / clear control for one window column cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // per-item control carried from the counter stage to the window stage
  typedef struct packed {
    logic b;         // incoming pixel is object
    logic br1;       // result for the last column of the row before last
    logic have;      // item produces a result
    logic eof;       // result closes the frame
    logic top_ok;    // neighbor row above lies inside the image
    logic bot_ok;    // neighbor row below lies inside the image
    logic left_ok;   // neighbor column left lies inside the image
    logic right_ok;  // neighbor column right lies inside the image
  } item_t;

  // morphology decision on a window; bit 3*col+row, col/row 0 is left/top
  function automatic logic decide(
    input logic [WIN_BITS-1:0] win,
    input logic [WIN_BITS-1:0] mask,
    input logic [1:0]          mode,
    input item_t               it
  );
    logic [2:0]          rok;
    logic [2:0]          cok;
    logic [WIN_BITS-1:0] inb;
    logic [WIN_BITS-1:0] live;
    logic [WIN_BITS-1:0] tmask;
    logic [WIN_BITS-1:0] rmask;
    logic                dil;
    logic                ero;
    logic                res;
    rok = {it.bot_ok, 1'b1, it.top_ok};
    cok = {it.right_ok, 1'b1, it.left_ok};
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        inb[j*3+i]   = rok[i] & cok[j];
        tmask[j*3+i] = mask[i*3+j];
      end
    end
    for (int k = 0; k < WIN_BITS; k++) begin
      rmask[k] = tmask[WIN_BITS-1-k];
    end
    live = win & inb;
    dil  = |(live & rmask);
    ero  = &(~tmask | live);
    case (mode)
      MODE_ERODE:    res = ero;
      MODE_BOUNDARY: res = win[4] & ~ero;
      default:       res = dil;
    endcase
    return res;
  endfunction

endpackage

>>> hw/rtl/bmorph_cell.sv
module bmorph_cell
  import bmorph_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctl_t           ctl,
  input  logic [WIN_ROWS-1:0] col_in,
  output logic [WIN_ROWS-1:0] col_out
);

  logic [WIN_ROWS-1:0] col_r;
  logic [WIN_ROWS-1:0] col_nxt;

  // take the neighbor's column on shift, clear wins
  always_comb begin
    col_nxt = col_r;
    if (ctl.shift) begin
      col_nxt = col_in;
    end
    if (ctl.clear) begin
      col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

endmodule

>>> hw/rtl/bmorph_lines.sv
module bmorph_lines
  import bmorph_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  output logic [1:0]    rd_data
);

  // bit 0 upper line, bit 1 middle line, same column
  logic [1:0] mem [DEPTH];
  logic [1:0] rd_r;
  logic [1:0] byp_data_r;
  logic       byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, forward a write to the same column in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r       <= mem[rd_addr];
      byp_r      <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_r;

endmodule

>>> hw/rtl/binary_morphology_3x3.sv
// 3x3 binary erosion / dilation / boundary on a raster pixel stream.
// input channel: in_valid / in_stall, one beat per pixel (in_req_type 0) or
//   drain beat (in_req_type 1); a pixel byte of 0 is object.
// output channel: out_valid / out_stall, one beat per result pixel, 0 object
//   or 255 background, with end of line and end of frame marks.
// a result trails its pixel by one row plus one column; after the last
//   pixel of a frame, image_width+1 drain beats flush the remaining results.
//   drain beats sent while the frame is still coming in are taken and dropped.
// throughput: one beat per cycle; the window is a chain of three column cells
//   and both line stores sit in one memory read and written once per beat.
// each result passes the stage register, then the result register, to out_valid.
// when out_stall holds a result, in_stall rises in the same cycle and the
//   whole pipeline freezes; the result register keeps its payload.
// reset: counters, window and valid flags clear, registers take their reset
//   values; the line stores are not cleared, rows outside the image are masked.
// writing image_width or image_height restarts the frame; write the registers
//   only while no result is pending.
`include "binary_morphology_3x3_defines.svh"

module binary_morphology_3x3
  import bmorph_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_pixel_in,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel_out,
  output logic        out_end_of_line,
  output logic        out_end_of_frame,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CIW  = (CW > DIM_W) ? CW : DIM_W;
  localparam int WCAP = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;

  // ---------------- configuration registers ----------------
  logic [1:0]          op_mode_r;
  logic [WIN_BITS-1:0] mask_r;
  logic [DIM_W-1:0]    img_w_r;
  logic [DIM_W-1:0]    img_h_r;
  logic                cfg_wr;
  logic                restart;
  reg_idx_t            widx;

  assign pready  = 1'b1;
  assign widx    = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign restart = cfg_wr && ((widx == REG_IMAGE_WIDTH) || (widx == REG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r <= MODE_DILATE;
      mask_r    <= MASK_RST;
      img_w_r   <= WIDTH_RST;
      img_h_r   <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (widx)
        REG_OP_MODE:      op_mode_r <= pwdata[1:0];
        REG_ELEMENT_MASK: mask_r    <= pwdata[WIN_BITS-1:0];
        REG_IMAGE_WIDTH:  img_w_r   <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: img_h_r   <= pwdata[DIM_W-1:0];
        default:          op_mode_r <= op_mode_r;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (widx)
      REG_OP_MODE:      prdata = {30'd0, op_mode_r};
      REG_ELEMENT_MASK: prdata = {23'd0, mask_r};
      REG_IMAGE_WIDTH:  prdata = {20'd0, img_w_r};
      REG_IMAGE_HEIGHT: prdata = {20'd0, img_h_r};
      default:          prdata = '0;
    endcase
  end

  // effective frame size
  logic [DIM_W-1:0] eff_w;
  logic [DIM_W-1:0] eff_h;
  logic [DIM_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;

  always_comb begin
    if (img_w_r == '0) begin
      eff_w = DIM_W'(1);
    end else if (int'(img_w_r) > WCAP) begin
      eff_w = DIM_W'(WCAP);
    end else begin
      eff_w = img_w_r;
    end
    eff_h = (img_h_r == '0) ? DIM_W'(1) : img_h_r;
    w_m1  = eff_w - DIM_W'(1);
    h_m1  = ROW_W'(eff_h) - ROW_W'(1);
  end

  // ---------------- handshake ----------------
  logic out_valid_r;
  logic en;
  logic acc;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign acc      = in_valid && en;

  // ---------------- counter stage ----------------
  logic [CIW-1:0]   in_col_r;
  logic [CIW-1:0]   in_col_nxt;
  logic [ROW_W-1:0] in_row_r;
  logic [ROW_W-1:0] in_row_nxt;
  logic             active;
  logic             ignore;
  logic             br1;
  logic             br2;
  logic             col_last;
  logic [ROW_W-1:0] out_row;
  logic [CIW-1:0]   out_col;
  item_t            it0;

  always_comb begin
    active   = in_row_r < ROW_W'(eff_h);
    ignore   = active && in_req_type;
    col_last = in_col_r == CIW'(w_m1);
    br1      = (in_col_r == '0) && (in_row_r >= ROW_W'(2));
    br2      = (in_col_r != '0) && (in_row_r != '0);
    out_row  = in_row_r - (br1 ? ROW_W'(2) : ROW_W'(1));
    out_col  = br1 ? CIW'(w_m1) : (in_col_r - CIW'(1));

    it0.b        = active && (in_pixel_in == PIX_OBJECT);
    it0.br1      = br1;
    it0.have     = br1 || br2;
    it0.eof      = br1 && (out_row == h_m1);
    it0.top_ok   = out_row != '0;
    it0.bot_ok   = out_row != h_m1;
    it0.left_ok  = out_col != '0;
    it0.right_ok = !br1;

    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    if (restart) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
    end else if (acc && !ignore) begin
      if (it0.eof) begin
        in_col_nxt = '0;
        in_row_nxt = '0;
      end else if (col_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + CIW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
    end else begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
    end
  end

  // ---------------- stage register into the window stage ----------------
  logic          s1_valid_r;
  logic          s1_valid_nxt;
  item_t         s1_it_r;
  logic [CW-1:0] s1_col_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (restart) begin
      s1_valid_nxt = 1'b0;
    end else if (en) begin
      s1_valid_nxt = acc && !ignore;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_it_r  <= it0;
      s1_col_r <= in_col_r[CW-1:0];
    end
  end

  // ---------------- line stores ----------------
  logic [1:0] ls_rd;
  logic       s1_go;

  assign s1_go = en && s1_valid_r;

  bmorph_lines #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_lines (
    .clk     (clk),
    .rd_en   (en),
    .rd_addr (in_col_r[CW-1:0]),
    .wr_en   (s1_go),
    .wr_addr (s1_col_r),
    .wr_data ({s1_it_r.b, ls_rd[1]}),
    .rd_data (ls_rd)
  );

  // ---------------- window: chain of column cells ----------------
  logic [WIN_ROWS-1:0] new_col;
  logic [WIN_ROWS-1:0] col_q [3];
  cell_ctl_t           cctl;

  assign new_col    = {s1_it_r.b, ls_rd[1], ls_rd[0]};
  assign cctl.shift = s1_go;
  assign cctl.clear = restart || (s1_go && s1_it_r.eof);

  for (genvar g = 0; g < 3; g++) begin : g_cell
    bmorph_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cctl),
      .col_in  ((g == 2) ? new_col : col_q[(g + 1) % 3]),
      .col_out (col_q[g])
    );
  end

  // window used for the result
  logic [WIN_BITS-1:0] win_used;
  logic                obj;

  always_comb begin
    if (s1_it_r.br1) begin
      win_used = {3'b000, col_q[2], col_q[1]};
    end else begin
      win_used = {new_col, col_q[2], col_q[1]};
    end
    obj = decide(win_used, mask_r, op_mode_r, s1_it_r);
  end

  // ---------------- result register ----------------
  logic       out_valid_nxt;
  logic [7:0] pix_r;
  logic       eol_r;
  logic       eof_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (en) begin
      out_valid_nxt = s1_valid_r && s1_it_r.have;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= obj ? PIX_OBJECT : PIX_BACKGR;
      eol_r <= s1_it_r.br1;
      eof_r <= s1_it_r.eof;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = pix_r;
  assign out_end_of_line  = eol_r;
  assign out_end_of_frame = eof_r;

  // ---------------- checks ----------------
  `BMORPH_ASSERT_IMP(a_eof_has_eol, out_valid_r && eof_r, eol_r)
  `BMORPH_ASSERT_IMP(a_pix_binary, out_valid_r,
                     (pix_r == PIX_OBJECT) || (pix_r == PIX_BACKGR))
  `BMORPH_ASSERT_NXT(a_hold_on_stall, s1_valid_r && !en && !restart, s1_valid_r)
  `BMORPH_ASSERT_IMP(a_col_in_range, !restart, in_col_r <= CIW'(w_m1))
  `BMORPH_ASSERT_NXT(a_eof_wraps, acc && !ignore && it0.eof && !restart,
                     (in_row_r == '0) && (in_col_r == '0))

endmodule

>>> verif/binary_morphology_3x3_tb.sv
`timescale 1ns / 100ps

module binary_morphology_3x3_tb;
  import bmorph_pkg::*;

  localparam int LINE_DEPTH  = 2048;
  localparam int TOTAL_ITEMS = 900;
  localparam int SETTLE      = 8;

  typedef struct {
    logic [7:0] pix;
    logic       eol;
    logic       eof;
  } morph_result_t;

  // shadow of the window pipeline and the queue of pixels it predicts
  class morph_scoreboard;
    bit                  upper_line[LINE_DEPTH];
    bit                  middle_line[LINE_DEPTH];
    logic [WIN_BITS-1:0] window;
    int                  in_col;
    int                  in_row;
    int                  out_col;
    int                  out_row;
    logic [1:0]          mode;
    logic [WIN_BITS-1:0] mask;
    int                  width_reg;
    int                  height_reg;
    morph_result_t       expected_pixels[$];
    int                  errors;

    function new();
      mode       = MODE_DILATE;
      mask       = MASK_RST;
      width_reg  = int'(WIDTH_RST);
      height_reg = int'(HEIGHT_RST);
      errors     = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      window  = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int eff_width();
      if (width_reg < 1) return 1;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int eff_height();
      return (height_reg < 1) ? 1 : height_reg;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // size writes restart the frame, mode and mask act at once
    function void set_register(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_OP_MODE:      mode = val[1:0];
        REG_ELEMENT_MASK: mask = val[8:0];
        REG_IMAGE_WIDTH: begin
          width_reg = int'(val[11:0]);
          restart_frame();
        end
        REG_IMAGE_HEIGHT: begin
          height_reg = int'(val[11:0]);
          restart_frame();
        end
        default: ;
      endcase
    endfunction

    // column dc+1 holds three bits, row dr+1 within it
    function bit win_at(logic [WIN_BITS-1:0] win, int dr, int dc);
      return win[(dc + 1) * 3 + (dr + 1)];
    endfunction

    function bit in_image(int r, int c, int w, int h);
      return r >= 0 && c >= 0 && r < h && c < w;
    endfunction

    function logic [7:0] morph_decision(logic [WIN_BITS-1:0] win, int row, int col,
                                        int w, int h);
      bit dil;
      bit ero;
      bit obj;
      int dr;
      int dc;
      dil = 1'b0;
      ero = 1'b1;
      for (int m = 0; m < 3; m++) begin
        for (int n = 0; n < 3; n++) begin
          if (mask[m * 3 + n]) begin
            // dilation uses the reflected element
            dr = 1 - m;
            dc = 1 - n;
            if (in_image(row + dr, col + dc, w, h) && win_at(win, dr, dc)) dil = 1'b1;
            dr = m - 1;
            dc = n - 1;
            if (!in_image(row + dr, col + dc, w, h) || !win_at(win, dr, dc)) ero = 1'b0;
          end
        end
      end
      case (mode)
        MODE_ERODE:    obj = ero;
        MODE_BOUNDARY: obj = win_at(win, 0, 0) && !ero;
        default:       obj = dil;
      endcase
      return obj ? PIX_OBJECT : PIX_BACKGR;
    endfunction

    // one accepted input beat: shift the window, maybe emit a result
    function void take_pixel_beat(logic req, logic [7:0] px);
      int                  w;
      int                  h;
      int                  x;
      bit                  b;
      bit                  u;
      bit                  md;
      bit                  have;
      logic [WIN_BITS-1:0] used;
      morph_result_t       res;
      w    = eff_width();
      h    = eff_height();
      b    = 1'b0;
      have = 1'b0;
      used = '0;
      // drain beats during frame input are dropped
      if (in_row < h) begin
        if (req) return;
        b = (px == 8'd0);
      end
      if (in_col >= w) in_col = 0;
      // last column of the row before last
      if (in_col == 0 && in_row >= 2) begin
        used    = window >> 3;
        out_row = in_row - 2;
        out_col = w - 1;
        have    = 1'b1;
      end
      x  = in_col;
      u  = upper_line[x];
      md = middle_line[x];
      upper_line[x]  = md;
      middle_line[x] = b;
      window = {b, md, u, window[8:3]};
      if (in_col >= 1 && in_row >= 1) begin
        used    = window;
        out_row = in_row - 1;
        out_col = in_col - 1;
        have    = 1'b1;
      end
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (!have) return;
      res.pix = morph_decision(used, out_row, out_col, w, h);
      res.eol = (out_col == w - 1);
      res.eof = res.eol && (out_row == h - 1);
      expected_pixels.push_back(res);
      if (res.eof) begin
        in_row = 0;
        in_col = 0;
        window = '0;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns: %s", $time, msg);
    endtask

    task check_result(logic [7:0] pix, logic eol, logic eof);
      morph_result_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("result beat with nothing expected, pixel_out %0d", pix));
        return;
      end
      want = expected_pixels.pop_front();
      if (pix !== want.pix)
        report($sformatf("pixel_out got %0d expected %0d", pix, want.pix));
      if (eol !== want.eol)
        report($sformatf("end_of_line got %b expected %b", eol, want.eol));
      if (eof !== want.eof)
        report($sformatf("end_of_frame got %b expected %b", eof, want.eof));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [7:0]  in_pixel_in;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_pixel_out;
  logic        out_end_of_line;
  logic        out_end_of_frame;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  morph_scoreboard sb;
  int              burst_left;
  int              items_sent;

  binary_morphology_3x3 uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_pixel_in      (in_pixel_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_out    (out_pixel_out),
    .out_end_of_line  (out_end_of_line),
    .out_end_of_frame (out_end_of_frame),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result beats
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_pixel_out, out_end_of_line, out_end_of_frame);
  end

  // receiver stall pattern, stretches of varying density
  initial begin
    int pct;
    int span;
    @(negedge clk);
    forever begin
      case ($urandom_range(0, 4))
        0, 1:    pct = 0;
        2:       pct = 25;
        3:       pct = 50;
        default: pct = 80;
      endcase
      span = $urandom_range(16, 200);
      repeat (span) begin
        out_stall <= ($urandom_range(0, 99) < pct);
        @(negedge clk);
      end
    end
  end

  // overall time limit
  initial begin
    #6_000_000;
    $display("binary_morphology_3x3_tb failed");
    $finish;
  end

  function automatic logic [7:0] rand_pixel(int obj_pct);
    return ($urandom_range(0, 99) < obj_pct) ? 8'd0 : 8'($urandom_range(1, 255));
  endfunction

  // one input beat, called at a falling edge; bursts end in random gaps or none
  task automatic send_beat(logic req, logic [7:0] px);
    int gap;
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_pixel_in <= px;
    do @(posedge clk); while (in_stall);
    sb.take_pixel_beat(req, px);
    items_sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // frame pixels, with stray drain beats mixed in that the block drops
  task automatic feed_pixels(int n, int obj_pct, int noise_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_beat(1'b1, 8'($urandom));
      send_beat(1'b0, rand_pixel(obj_pct));
    end
  endtask

  // flush beats after the frame: drains, some pixels that act as drains
  task automatic flush_frame(int n, int px_pct);
    for (int i = 0; i < n; i++) begin
      send_beat(($urandom_range(0, 99) < px_pct) ? 1'b0 : 1'b1, 8'($urandom));
    end
  endtask

  // drop valid, wait for every result, let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // apb write: setup then access
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(logic [1:0] mode_v, logic [8:0] mask_v, int w, int h);
    write_reg(REG_OP_MODE, 32'(mode_v));
    write_reg(REG_ELEMENT_MASK, 32'(mask_v));
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // one full frame at the given size
  task automatic big_frame(int w, int h);
    configure(2'($urandom_range(0, 3)), 9'($urandom), w, h);
    feed_pixels(sb.eff_width() * sb.eff_height(), 50, 0);
    flush_frame(sb.eff_width() + 1, 20);
    wait_idle();
  endtask

  initial begin
    logic [1:0] mode_v;
    logic [8:0] mask_v;
    int         w;
    int         h;
    int         nframes;
    int         obj_pct;
    int         npix;
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = 1'b0;
    in_pixel_in = 8'd0;
    out_stall   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    burst_left  = 8;
    items_sent  = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // dilation, full element, 3x2 frame; stray drain inside, pixel among flush
    configure(MODE_DILATE, MASK_RST, 3, 2);
    send_beat(1'b0, 8'd0);
    send_beat(1'b0, 8'd255);
    send_beat(1'b0, 8'd1);
    send_beat(1'b1, 8'h5a);
    send_beat(1'b0, 8'd128);
    send_beat(1'b0, 8'd0);
    send_beat(1'b0, 8'd0);
    send_beat(1'b1, 8'd0);
    send_beat(1'b1, 8'd255);
    send_beat(1'b0, 8'h7f);
    send_beat(1'b1, 8'd0);
    wait_idle();

    // erosion with an empty element, zero sizes act as one
    configure(MODE_ERODE, 9'd0, 0, 0);
    send_beat(1'b0, 8'd0);
    send_beat(1'b1, 8'd0);
    send_beat(1'b1, 8'd0);
    wait_idle();

    // mode and mask changed in the middle of a frame
    configure(MODE_DILATE, 9'h0ba, 2, 2);
    send_beat(1'b0, 8'd0);
    send_beat(1'b0, 8'd255);
    wait_idle();
    write_reg(REG_OP_MODE, 32'(MODE_BOUNDARY));
    write_reg(REG_ELEMENT_MASK, 32'h145);
    send_beat(1'b0, 8'd0);
    send_beat(1'b0, 8'd0);
    flush_frame(3, 0);
    wait_idle();

    // unused mode code, frame cut short and restarted by the next size write
    configure(2'd3, MASK_RST, 1, 2);
    send_beat(1'b0, 8'd255);
    send_beat(1'b0, 8'd0);
    send_beat(1'b1, 8'd0);
    wait_idle();

    // width above the store saturates, no result within the first row
    configure(MODE_ERODE, MASK_RST, 4095, 3);
    feed_pixels(48, 50, 0);
    wait_idle();

    // tall one-column frame
    big_frame(1, 240);

    // random phases of small frames
    while (items_sent < TOTAL_ITEMS) begin
      mode_v = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0:       mask_v = 9'd0;
        1:       mask_v = 9'h1ff;
        default: mask_v = 9'($urandom);
      endcase
      w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
      h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
      configure(mode_v, mask_v, w, h);
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
        obj_pct = 10 + 40 * $urandom_range(0, 2);
        npix    = sb.eff_width() * sb.eff_height();
        // now and then a broken frame ends the phase
        if ($urandom_range(0, 9) == 0) begin
          feed_pixels($urandom_range(1, npix), obj_pct, 5);
          if ($urandom_range(0, 1)) flush_frame($urandom_range(0, sb.eff_width()), 20);
          break;
        end
        feed_pixels(npix, obj_pct, 5);
        flush_frame(sb.eff_width() + 1, 20);
      end
      wait_idle();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("binary_morphology_3x3_tb passed");
    end else begin
      $display("binary_morphology_3x3_tb failed");
    end
    $finish;
  end

endmodule
